// ===== rtl/gradient_noise_2d_assert.svh =====
// assertion macros used by the gradient noise top level
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define GN2D_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define GN2D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gn2d_pkg.sv =====
// shared constants and types of the gradient noise block
package gn2d_pkg;

   // permutation table
   localparam int TABLE_DEPTH = 512;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int VAL_W       = 9;

   // coordinates and fractions
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int CELL_W  = COORD_W - FRAC_W;
   localparam int ONE_Q16 = 1 << FRAC_W;

   // gradient and dot product widths
   localparam int GRAD_W    = VAL_W + 1;
   localparam int GRAD_BIAS = 256;
   localparam int OFS_W     = FRAC_W + 1;
   localparam int PROD_W    = GRAD_W + OFS_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int MAG_W     = PROD_W - 1;
   localparam int SQ_W      = 2 * GRAD_W - 2;
   localparam int ROOT_W    = (SQ_W + FRAC_W) / 2;
   localparam int NUM_SHIFT = 8;
   localparam int NUM_W     = MAG_W + NUM_SHIFT;
   localparam int QUO_W     = 18;
   localparam int DOT_W     = QUO_W + 1;

   // per corner pipeline: product, sum, root steps, divide steps, sign
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int CORNER_LAT = 3 + SQRT_STEPS + DIV_STEPS;

   // fade curve 6t^5 - 15t^4 + 10t^3
   localparam int FADE_W   = FRAC_W + 1;
   localparam int FADE_A   = 6;
   localparam int FADE_B   = 15;
   localparam int FADE_C   = 10 * ONE_Q16;
   localparam int FADE_Q_W = FRAC_W + 4;
   localparam int FADE_LAT = 4;
   localparam int FADE_DLY = CORNER_LAT - FADE_LAT;

   // blend and result
   localparam int LP_W     = FADE_W + 1 + DOT_W;
   localparam int LS_W     = LP_W + 1;
   localparam int OUT_W    = 16;
   localparam int PIPE_LAT = 1 + CORNER_LAT + 3;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_EVAL = 1'b1
   } action_type;

   typedef logic signed [DOT_W-1:0] dot_type;
   typedef logic        [FADE_W-1:0] fade_type;

endpackage

// ===== rtl/gn2d_corner.sv =====
// one corner: gradient, length by digit-serial root, dot by pipelined divide
module gn2d_corner import gn2d_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic [VAL_W-1:0]        vx,
   input  logic [VAL_W-1:0]        vy,
   input  logic signed [OFS_W-1:0] dx,
   input  logic signed [OFS_W-1:0] dy,
   output dot_type                 dot
);

   localparam int REM_W   = ROOT_W + 2;
   localparam int ACC_W   = ROOT_W + 4;
   localparam int SQ_N_W  = 2 * ROOT_W;
   localparam int SQP_W   = 2 * GRAD_W;

   logic signed [GRAD_W-1:0] gx;
   logic signed [GRAD_W-1:0] gy;
   logic signed [PROD_W-1:0] px_ff, py_ff;
   logic signed [SQP_W-1:0]  sxx_ff, syy_ff;
   logic signed [SQP_W-1:0]  sq_sum;
   logic signed [SUM_W-1:0]  num_sum;
   logic [MAG_W-1:0]         c2_mag_ff;
   logic                     c2_neg_ff;
   logic                     c2_zero_ff;
   logic [SQ_W-1:0]          c2_s_ff;

   logic [REM_W-1:0]  sq_rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0] sq_root_ff [SQRT_STEPS];
   logic [SQ_W-1:0]   sq_s_ff    [SQRT_STEPS];
   logic [MAG_W-1:0]  sq_mag_ff  [SQRT_STEPS];
   logic              sq_neg_ff  [SQRT_STEPS];
   logic              sq_zero_ff [SQRT_STEPS];

   logic [ROOT_W-1:0] dv_rem_ff  [DIV_STEPS];
   logic [ROOT_W-1:0] dv_d_ff    [DIV_STEPS];
   logic [QUO_W-1:0]  dv_q_ff    [DIV_STEPS];
   logic [MAG_W-1:0]  dv_mag_ff  [DIV_STEPS];
   logic              dv_neg_ff  [DIV_STEPS];
   logic              dv_zero_ff [DIV_STEPS];

   dot_type           dot_in, dot_ff;
   logic [QUO_W-1:0]  q_last;

   assign gx = $signed({1'b0, vx}) - $signed(GRAD_W'(GRAD_BIAS));
   assign gy = $signed({1'b0, vy}) - $signed(GRAD_W'(GRAD_BIAS));

   // products of gradient and offset, and squares of the gradient
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= PROD_W'(gx) * PROD_W'(dx);
         py_ff  <= PROD_W'(gy) * PROD_W'(dy);
         sxx_ff <= SQP_W'(gx) * SQP_W'(gx);
         syy_ff <= SQP_W'(gy) * SQP_W'(gy);
      end
   end

   assign num_sum = SUM_W'(px_ff) + SUM_W'(py_ff);
   assign sq_sum  = sxx_ff + syy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c2_neg_ff  <= num_sum[SUM_W-1];
         c2_mag_ff  <= num_sum[SUM_W-1] ? MAG_W'(-num_sum) : MAG_W'(num_sum);
         c2_s_ff    <= sq_sum[SQ_W-1:0];
         c2_zero_ff <= (sq_sum == '0);
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
      localparam int P = SQRT_STEPS - 1 - k;
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [SQ_W-1:0]   s_p;
      logic [MAG_W-1:0]  mag_p;
      logic              neg_p, zero_p;
      logic [SQ_N_W-1:0] n_w;
      logic [ACC_W-1:0]  acc, trial;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign s_p    = c2_s_ff;
         assign mag_p  = c2_mag_ff;
         assign neg_p  = c2_neg_ff;
         assign zero_p = c2_zero_ff;
      end else begin : g_next
         assign rem_p  = sq_rem_ff[k-1];
         assign root_p = sq_root_ff[k-1];
         assign s_p    = sq_s_ff[k-1];
         assign mag_p  = sq_mag_ff[k-1];
         assign neg_p  = sq_neg_ff[k-1];
         assign zero_p = sq_zero_ff[k-1];
      end

      assign n_w   = {s_p, {(SQ_N_W - SQ_W){1'b0}}};
      assign acc   = {rem_p, n_w[2*P +: 2]};
      assign trial = {2'b00, root_p, 2'b01};
      assign take  = (acc >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k]  <= take ? REM_W'(acc - trial) : REM_W'(acc);
            sq_root_ff[k] <= {root_p[ROOT_W-2:0], take};
            sq_s_ff[k]    <= s_p;
            sq_mag_ff[k]  <= mag_p;
            sq_neg_ff[k]  <= neg_p;
            sq_zero_ff[k] <= zero_p;
         end
      end
   end

   // restoring divide of |numerator| * 256 by the length, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
      localparam int B = DIV_STEPS - 1 - j;
      logic [ROOT_W-1:0] rem_p;
      logic [ROOT_W-1:0] d_p;
      logic [QUO_W-1:0]  q_p;
      logic [MAG_W-1:0]  mag_p;
      logic              neg_p, zero_p;
      logic [NUM_W-1:0]  num_w;
      logic [ROOT_W:0]   t, dd;
      logic              take;

      if (j == 0) begin : g_first
         assign rem_p  = ROOT_W'(num_w[NUM_W-1:QUO_W]);
         assign d_p    = sq_root_ff[SQRT_STEPS-1];
         assign q_p    = '0;
         assign mag_p  = sq_mag_ff[SQRT_STEPS-1];
         assign neg_p  = sq_neg_ff[SQRT_STEPS-1];
         assign zero_p = sq_zero_ff[SQRT_STEPS-1];
      end else begin : g_next
         assign rem_p  = dv_rem_ff[j-1];
         assign d_p    = dv_d_ff[j-1];
         assign q_p    = dv_q_ff[j-1];
         assign mag_p  = dv_mag_ff[j-1];
         assign neg_p  = dv_neg_ff[j-1];
         assign zero_p = dv_zero_ff[j-1];
      end

      assign num_w = {mag_p, {NUM_SHIFT{1'b0}}};
      assign t     = {rem_p, num_w[B]};
      assign dd    = {1'b0, d_p};
      assign take  = (t >= dd);

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j]  <= take ? ROOT_W'(t - dd) : ROOT_W'(t);
            dv_d_ff[j]    <= d_p;
            dv_q_ff[j]    <= {q_p[QUO_W-2:0], take};
            dv_mag_ff[j]  <= mag_p;
            dv_neg_ff[j]  <= neg_p;
            dv_zero_ff[j] <= zero_p;
         end
      end
   end

   // sign back on, zero gradient gives zero
   assign q_last = dv_q_ff[DIV_STEPS-1];

   always_comb begin
      if (dv_zero_ff[DIV_STEPS-1]) begin
         dot_in = '0;
      end else if (dv_neg_ff[DIV_STEPS-1]) begin
         dot_in = -$signed({1'b0, q_last});
      end else begin
         dot_in = $signed({1'b0, q_last});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff <= dot_in;
      end
   end

   assign dot = dot_ff;

endmodule

// ===== rtl/gradient_noise_2d.sv =====
// top level of the two-dimensional gradient noise block
`include "gradient_noise_2d_assert.svh"

// usage
//   req channel: req_valid / req_stall carry one item per accepted edge
//   req_action load writes req_entry_value into the permutation table at
//   req_entry_index and returns nothing; evaluate takes req_coord_x and
//   req_coord_y (q15.16) and returns one rsp item with rsp_noise_value (q0.15)
//   rsp channel: rsp_valid / rsp_stall, results leave in acceptance order
//   throughput: one item per cycle while req_stall is low, loads and evaluates freely mixed
//   an evaluate result reaches the output register through the fetch registers,
//   the per-corner product, sum, root and divide stages (17 and 18 stages) and
//   sign register, then the fade blend registers
//   a load is visible to any evaluate accepted on a later edge
//   the table has no defined contents after reset; entries are written by loads
//   reset clears the pipeline valid bits and the output and skid valid bits
//   when the receiver stalls, one more result drops into a skid register and
//   the pipeline carries on; req_stall rises and the pipeline halts only while the skid is full
module gradient_noise_2d import gn2d_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [VAL_W-1:0]         req_entry_index,
   input  logic [VAL_W-1:0]         req_entry_value,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_noise_value
);

   localparam int T2_W = 2 * FRAC_W;
   localparam int FP_W = FRAC_W + FADE_Q_W;
   localparam int QS_W = FADE_Q_W + 2;

   // handshake and pipeline enable
   logic en;
   logic accept;
   logic is_eval;
   logic push;
   logic out_take;

   // table copies: x parts read at both x cells, y parts at both y cells
   logic [VAL_W-1:0] perm_x_mem [TABLE_DEPTH];
   logic [VAL_W-1:0] perm_y_mem [TABLE_DEPTH];

   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  ix0, ix1, iy0, iy1;
   logic [CELL_W-1:0] cell_x, cell_y;

   logic [VAL_W-1:0]  vx0_ff, vx1_ff, vy0_ff, vy1_ff;
   logic [FRAC_W-1:0] fx_ff, fy_ff;

   logic signed [OFS_W-1:0] dx0, dx1, dy0, dy1;
   dot_type d0, d1, d2, d3;

   logic [PIPE_LAT-1:0] vld_ff;

   // fade stages
   logic [FRAC_W-1:0]   f1_t_ff   [2];
   logic [FRAC_W-1:0]   f1_t2_ff  [2];
   logic [FRAC_W-1:0]   f2_t_ff   [2];
   logic [FRAC_W-1:0]   f2_t2_ff  [2];
   logic [FRAC_W-1:0]   f2_t3_ff  [2];
   logic [FRAC_W-1:0]   f3_t3_ff  [2];
   logic [FADE_Q_W-1:0] f3_q_ff   [2];
   fade_type            f4_f_ff   [2];
   fade_type            fdl_x_ff  [FADE_DLY];
   fade_type            fdl_y_ff  [FADE_DLY];

   // blend stages
   fade_type               ux, uy;
   fade_type               ux_inv;
   logic signed [LP_W-1:0] l1_p0_ff, l1_p1_ff, l1_p2_ff, l1_p3_ff;
   fade_type               l1_uy_ff, l2_uy_ff;
   logic signed [LS_W-1:0] l2_s01, l2_s23;
   dot_type                l2_a01_ff, l2_a23_ff;
   fade_type               uy_inv;
   logic signed [LP_W-1:0] l3_p0_ff, l3_p1_ff;
   logic signed [LS_W-1:0] l4_sum;
   dot_type                l4_r;
   logic signed [DOT_W-2:0] l4_half;
   logic                   l4_ovf;
   logic signed [OUT_W-1:0] result_in;

   // output register and skid
   logic                    out_vld_ff, skid_vld_ff;
   logic signed [OUT_W-1:0] out_data_ff, skid_data_ff;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !req_stall;
   assign is_eval   = (action_type'(req_action) == ACT_EVAL);

   // cell indices wrap by keeping the low bits of the floor cell
   assign wr_addr = IDX_W'(req_entry_index);
   assign cell_x  = req_coord_x[COORD_W-1:FRAC_W];
   assign cell_y  = req_coord_y[COORD_W-1:FRAC_W];
   assign ix0     = IDX_W'(cell_x);
   assign iy0     = IDX_W'(cell_y);
   assign ix1     = ix0 + IDX_W'(1);
   assign iy1     = iy0 + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (accept && !is_eval) begin
         perm_x_mem[wr_addr] <= req_entry_value;
         perm_y_mem[wr_addr] <= req_entry_value;
      end
      if (en) begin
         vx0_ff <= perm_x_mem[ix0];
         vx1_ff <= perm_x_mem[ix1];
         vy0_ff <= perm_y_mem[iy0];
         vy1_ff <= perm_y_mem[iy1];
         fx_ff  <= req_coord_x[FRAC_W-1:0];
         fy_ff  <= req_coord_y[FRAC_W-1:0];
      end
   end

   // near corner offset is the fraction, far corner the fraction minus one
   assign dx0 = $signed({1'b0, fx_ff});
   assign dx1 = $signed({1'b1, fx_ff});
   assign dy0 = $signed({1'b0, fy_ff});
   assign dy1 = $signed({1'b1, fy_ff});

   gn2d_corner u_corner0 (
      .clock (clock), .en (en), .vx (vx0_ff), .vy (vy0_ff), .dx (dx0), .dy (dy0), .dot (d0)
   );
   gn2d_corner u_corner1 (
      .clock (clock), .en (en), .vx (vx1_ff), .vy (vy0_ff), .dx (dx1), .dy (dy0), .dot (d1)
   );
   gn2d_corner u_corner2 (
      .clock (clock), .en (en), .vx (vx0_ff), .vy (vy1_ff), .dx (dx0), .dy (dy1), .dot (d2)
   );
   gn2d_corner u_corner3 (
      .clock (clock), .en (en), .vx (vx1_ff), .vy (vy1_ff), .dx (dx1), .dy (dy1), .dot (d3)
   );

   // only evaluate items travel as valid, loads leave no result
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], accept && is_eval};
      end
   end

   // fade for both axes, at most one multiply of two variables per stage
   for (genvar a = 0; a < 2; a++) begin : g_fade
      logic [FRAC_W-1:0]      t0;
      logic [T2_W-1:0]        p1, p2;
      logic signed [QS_W-1:0] q_full;
      logic [FP_W-1:0]        p4;
      logic [FADE_Q_W-1:0]    f_full;

      assign t0 = (a == 0) ? fx_ff : fy_ff;
      assign p1 = T2_W'(t0) * T2_W'(t0);
      assign p2 = T2_W'(f1_t2_ff[a]) * T2_W'(f1_t_ff[a]);
      assign q_full = QS_W'(FADE_A) * $signed({2'b00, FADE_Q_W'(f2_t2_ff[a])})
                    - QS_W'(FADE_B) * $signed({2'b00, FADE_Q_W'(f2_t_ff[a])})
                    + QS_W'(FADE_C);
      assign p4 = FP_W'(f3_t3_ff[a]) * FP_W'(f3_q_ff[a]);
      assign f_full = p4[FP_W-1:FRAC_W];

      always_ff @(posedge clock) begin
         if (en) begin
            f1_t_ff[a]  <= t0;
            f1_t2_ff[a] <= p1[T2_W-1:FRAC_W];
            f2_t_ff[a]  <= f1_t_ff[a];
            f2_t2_ff[a] <= f1_t2_ff[a];
            f2_t3_ff[a] <= p2[T2_W-1:FRAC_W];
            f3_t3_ff[a] <= f2_t3_ff[a];
            f3_q_ff[a]  <= q_full[QS_W-1] ? '0 : FADE_Q_W'(q_full);
            f4_f_ff[a]  <= (f_full > FADE_Q_W'(ONE_Q16)) ? FADE_W'(ONE_Q16)
                                                         : FADE_W'(f_full);
         end
      end
   end

   // hold the fades until the corner dots arrive
   always_ff @(posedge clock) begin
      if (en) begin
         fdl_x_ff[0] <= f4_f_ff[0];
         fdl_y_ff[0] <= f4_f_ff[1];
         for (int i = 1; i < FADE_DLY; i++) begin
            fdl_x_ff[i] <= fdl_x_ff[i-1];
            fdl_y_ff[i] <= fdl_y_ff[i-1];
         end
      end
   end

   assign ux     = fdl_x_ff[FADE_DLY-1];
   assign uy     = fdl_y_ff[FADE_DLY-1];
   assign ux_inv = FADE_W'(ONE_Q16) - ux;

   // blend along x
   always_ff @(posedge clock) begin
      if (en) begin
         l1_p0_ff <= LP_W'($signed({1'b0, ux_inv})) * LP_W'(d0);
         l1_p1_ff <= LP_W'($signed({1'b0, ux}))     * LP_W'(d1);
         l1_p2_ff <= LP_W'($signed({1'b0, ux_inv})) * LP_W'(d2);
         l1_p3_ff <= LP_W'($signed({1'b0, ux}))     * LP_W'(d3);
         l1_uy_ff <= uy;
      end
   end

   assign l2_s01 = LS_W'(l1_p0_ff) + LS_W'(l1_p1_ff);
   assign l2_s23 = LS_W'(l1_p2_ff) + LS_W'(l1_p3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         l2_a01_ff <= l2_s01[FRAC_W +: DOT_W];
         l2_a23_ff <= l2_s23[FRAC_W +: DOT_W];
         l2_uy_ff  <= l1_uy_ff;
      end
   end

   // blend along y
   assign uy_inv = FADE_W'(ONE_Q16) - l2_uy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         l3_p0_ff <= LP_W'($signed({1'b0, uy_inv}))   * LP_W'(l2_a01_ff);
         l3_p1_ff <= LP_W'($signed({1'b0, l2_uy_ff})) * LP_W'(l2_a23_ff);
      end
   end

   // floor halving and saturation to the output range
   assign l4_sum  = LS_W'(l3_p0_ff) + LS_W'(l3_p1_ff);
   assign l4_r    = l4_sum[FRAC_W +: DOT_W];
   assign l4_half = l4_r[DOT_W-1:1];
   assign l4_ovf  = !((&l4_half[DOT_W-2:OUT_W-1]) || !(|l4_half[DOT_W-2:OUT_W-1]));

   always_comb begin
      if (l4_ovf) begin
         result_in = l4_half[DOT_W-2] ? $signed({1'b1, {(OUT_W-1){1'b0}}})
                                      : $signed({1'b0, {(OUT_W-1){1'b1}}});
      end else begin
         result_in = l4_half[OUT_W-1:0];
      end
   end

   assign push     = en && vld_ff[PIPE_LAT-1];
   assign out_take = !out_vld_ff || !rsp_stall;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= push;
         end
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : result_in;
      end else if (push) begin
         skid_data_ff <= result_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_noise_value = out_data_ff;

   // checks
   `GN2D_ASSERT_IMPLY(a_skid_behind_out, skid_vld_ff, out_vld_ff, "skid full with empty output")
   `GN2D_ASSERT_NEXT(a_skid_fill, out_vld_ff && rsp_stall && push, skid_vld_ff, "result dropped")
   `GN2D_ASSERT_IMPLY(a_rsp_from_pipe, $rose(out_vld_ff), $past(push), "result not from pipeline")

endmodule

// ===== tb/sv/noise_checker.sv =====
// checker for the gradient noise block: predicts every evaluate and compares results
module noise_checker import gn2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_action,
   input  logic [VAL_W-1:0]          req_entry_index,
   input  logic [VAL_W-1:0]          req_entry_value,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [OUT_W-1:0]   rsp_noise_value,
   output int                        errors,
   output int                        pending
);

   logic [VAL_W-1:0]        perm_copy [TABLE_DEPTH];
   logic signed [OUT_W-1:0] noise_q [$];

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors = errors + 1;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint fade_curve(input longint t);
      longint t2, t3, q, f;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      q  = 6 * t2 - 15 * t + 10 * 65536;
      if (q < 0) q = 0;
      f = (t3 * q) >>> 16;
      return (f > 65536) ? 65536 : f;
   endfunction

   function automatic longint grad_dot(input int ix, input int iy, input longint dx,
                                       input longint dy);
      longint gx, gy, len8;
      gx   = longint'(perm_copy[ix]) - 256;
      gy   = longint'(perm_copy[iy]) - 256;
      len8 = longint'(int_sqrt(longint'(gx * gx + gy * gy) << 16));
      if (len8 == 0) return 0;
      return ((gx * dx + gy * dy) * 256) / len8;
   endfunction

   function automatic longint blend(input longint f, input longint a, input longint b);
      return ((65536 - f) * a + f * b) >>> 16;
   endfunction

   function automatic logic signed [OUT_W-1:0] noise_at(input logic signed [31:0] x,
                                                        input logic signed [31:0] y);
      longint fx, fy, cx, cy, ux, uy, d0, d1, d2, d3, r;
      int ix0, ix1, iy0, iy1;
      fx  = longint'(x[15:0]);
      fy  = longint'(y[15:0]);
      cx  = longint'(x) >>> 16;
      cy  = longint'(y) >>> 16;
      ix0 = int'(cx & 511);
      ix1 = int'((cx + 1) & 511);
      iy0 = int'(cy & 511);
      iy1 = int'((cy + 1) & 511);
      d0  = grad_dot(ix0, iy0, fx, fy);
      d1  = grad_dot(ix1, iy0, fx - 65536, fy);
      d2  = grad_dot(ix0, iy1, fx, fy - 65536);
      d3  = grad_dot(ix1, iy1, fx - 65536, fy - 65536);
      ux  = fade_curve(fx);
      uy  = fade_curve(fy);
      r   = blend(uy, blend(ux, d0, d1), blend(ux, d2, d3)) >>> 1;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_action == ACT_LOAD) perm_copy[req_entry_index] = req_entry_value;
            else noise_q.push_back(noise_at(req_coord_x, req_coord_y));
         end
         if (rsp_valid && !rsp_stall) begin
            if (noise_q.size() == 0) begin
               report($sformatf("unexpected result %0d", rsp_noise_value));
            end else begin
               want = noise_q.pop_front();
               if (rsp_noise_value !== want)
                  report($sformatf("noise_value %0d, predicted %0d", rsp_noise_value, want));
            end
         end
      end
      pending <= noise_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the gradient noise testbench: clock, reset, stimulus and verdict
module testbench;
   import gn2d_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_action;
   logic [VAL_W-1:0]          req_entry_index;
   logic [VAL_W-1:0]          req_entry_value;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [OUT_W-1:0]   rsp_noise_value;
   int                        errors;
   int                        pending;

   // idling rates in percent, set per phase
   int send_idle_pct;
   int recv_stall_pct;
   // bumped by the stimulus to ask the receiver for one long hold-off
   int hold_asks;
   int hold_seen;
   int hold_left;

   gradient_noise_2d u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_entry_index(req_entry_index), .req_entry_value(req_entry_value),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value)
   );

   noise_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_entry_index(req_entry_index), .req_entry_value(req_entry_value),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random stall, or a long counted hold-off when asked
   initial begin
      rsp_stall <= 1'b1;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // offer one item and wait until it is taken, idling first at random
   task automatic send_item(input logic act, input logic [8:0] idx, input logic [8:0] val,
                            input logic [31:0] x, input logic [31:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_coord_x     <= x;
      req_coord_y     <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_entry(input logic [8:0] idx, input logic [8:0] val);
      send_item(ACT_LOAD, idx, val, $urandom, $urandom);
   endtask

   task automatic eval_point(input logic [31:0] x, input logic [31:0] y);
      send_item(ACT_EVAL, 9'($urandom), 9'($urandom), x, y);
   endtask

   // mostly evaluates, some loads; coordinates either anywhere or near the origin
   task automatic random_item();
      logic [31:0] x, y;
      if ($urandom_range(99) < 25) begin
         load_entry(9'($urandom), ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom));
      end else begin
         if ($urandom_range(1) == 0) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = 32'($signed($urandom_range(2 ** 22)) - 2 ** 21);
            y = 32'($signed($urandom_range(2 ** 22)) - 2 ** 21);
         end
         eval_point(x, y);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      send_idle_pct  = 20;
      recv_stall_pct = 64;
      hold_asks      = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_action      <= ACT_LOAD;
      req_entry_index <= '0;
      req_entry_value <= '0;
      req_coord_x     <= '0;
      req_coord_y     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table so no evaluate ever reads an unwritten entry
      for (n = 0; n < TABLE_DEPTH; n++) load_entry(9'(n), 9'($urandom));

      // directed: value extremes, a zero gradient cell, coordinate extremes
      load_entry(9'd0, 9'd0);
      load_entry(9'd511, 9'd511);
      load_entry(9'd1, 9'd511);
      load_entry(9'd5, 9'd256);
      load_entry(9'd6, 9'd256);
      eval_point(32'h0000_0000, 32'h0000_0000);
      eval_point(32'h0000_8000, 32'h0000_8000);
      eval_point(32'h0000_ffff, 32'h0000_ffff);
      eval_point(32'h7fff_ffff, 32'h7fff_ffff);
      eval_point(32'h8000_0000, 32'h8000_0000);
      eval_point(32'h7fff_ffff, 32'h8000_0000);
      eval_point(32'hffff_ffff, 32'hffff_ffff);
      eval_point(32'hffff_0000, 32'h0001_0000);
      eval_point(32'h0005_8000, 32'h0005_8000); // zero gradient at every corner
      eval_point(32'h0005_4000, 32'h0006_c000);
      eval_point(32'h01ff_1234, 32'hfe00_abcd); // far corners wrap past the table end
      eval_point(32'h0000_0001, 32'h0001_ffff);

      // random phases with different idling
      for (n = 0; n < 125; n++) random_item();
      send_idle_pct  = 64;
      recv_stall_pct = 20;
      for (n = 0; n < 125; n++) random_item();
      drain(); // sender pauses until every result is back

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks = hold_asks + 1; // receiver holds off while items keep coming
      for (n = 0; n < 125; n++) random_item();

      drain();
      req_valid <= 1'b0;
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gn2d_pkg.sv
rtl/gn2d_corner.sv
rtl/gradient_noise_2d.sv
tb/sv/noise_checker.sv
tb/sv/testbench.sv
